>>> sv/line_clipper_rect_window_assert.svh
// Assertion macros shared by the clipper checks.
// Each macro takes a label, a condition and a consequence, sampled on clk.
`ifndef LINE_CLIPPER_RECT_WINDOW_ASSERT_SVH
`define LINE_CLIPPER_RECT_WINDOW_ASSERT_SVH

// The consequence holds in the same cycle as the condition.
`define LCRW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcrw check failed");

// The consequence holds in the cycle after the condition.
`define LCRW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcrw check failed");

`endif

>>> sv/lcrw_pkg.sv
package lcrw_pkg;

	// Coordinate width of the segment and result fields and the window registers.
	localparam int COORD_BITS = 16;
	// Default fraction width of the clip parameters t0 and t1.
	localparam int T_FRAC_DEF = 16;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEFT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_BOTTOM = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_RIGHT  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_TOP    = 2'd3;

	// Window values after reset.
	localparam logic signed [COORD_BITS-1:0] WIN_LEFT_RST   = COORD_BITS'(100);
	localparam logic signed [COORD_BITS-1:0] WIN_BOTTOM_RST = COORD_BITS'(100);
	localparam logic signed [COORD_BITS-1:0] WIN_RIGHT_RST  = COORD_BITS'(300);
	localparam logic signed [COORD_BITS-1:0] WIN_TOP_RST    = COORD_BITS'(300);

	// One segment request.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} seg_t;

	// One clipped result.
	typedef struct packed {
		logic                         visible;
		logic signed [COORD_BITS-1:0] clip_start_x;
		logic signed [COORD_BITS-1:0] clip_start_y;
		logic signed [COORD_BITS-1:0] clip_end_x;
		logic signed [COORD_BITS-1:0] clip_end_y;
	} clip_t;

	// Segment data and per-edge flags that ride along the divider.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [COORD_BITS:0]   dx;
		logic signed [COORD_BITS:0]   dy;
		logic [3:0]                   rej;
		logic [3:0]                   act;
		logic [3:0]                   ent;
		logic [3:0]                   sat;
	} lane_ctx_t;

endpackage

>>> sv/line_clipper_rect_window.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------
// segment   | in        | in_valid / in_stall  | seg_in (seg_t)
// result    | out       | out_valid / out_stall| clip_out (clip_t)
// config    | in        | cfg_we               | cfg_idx, cfg_data
//
// One segment enters per cycle while in_stall is low; its result is offered after passing
// through the T_FRAC_BITS + 8 pipeline stages.
// The depth grows with T_FRAC_BITS through the four-lane restoring divider, one quotient bit per stage.
// Reset clears the valid bits and loads the window registers; there is no clearing pass.
// A stalled result holds; earlier stages keep filling bubbles, so input stalls only
// when every stage is full and the result is stalled.
module line_clipper_rect_window import lcrw_pkg::*; #(
	parameter int T_FRAC_BITS = T_FRAC_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  seg_t                    seg_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output clip_t                   clip_out,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [COORD_BITS-1:0]   cfg_data
);

	localparam int C  = COORD_BITS;
	localparam int F  = T_FRAC_BITS;
	localparam int TW = F + 1;
	localparam int DW = C + 1;
	localparam int RW = C + 2;
	localparam int NS = F + 8;
	localparam int PW = TW + 1 + DW;
	localparam int SW = PW + 1;

	typedef struct packed {
		logic          ok;
		logic [TW-1:0] t0;
		logic [TW-1:0] t1;
	} dec_t;

	// One edge of the clip test.
	function automatic dec_t edge_step(dec_t d, logic rej, logic act, logic ent,
			logic [TW-1:0] t);
		dec_t r;
		r = d;
		if (d.ok) begin
			if (rej) begin
				r.ok = 1'b0;
			end else if (act) begin
				if (ent) begin
					if (t > d.t1) r.ok = 1'b0;
					else if (t > d.t0) r.t0 = t;
				end else begin
					if (t < d.t0) r.ok = 1'b0;
					else if (t < d.t1) r.t1 = t;
				end
			end
		end
		return r;
	endfunction

	// Window registers.
	logic signed [C-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= WIN_LEFT_RST;
			win_bottom_q <= WIN_BOTTOM_RST;
			win_right_q  <= WIN_RIGHT_RST;
			win_top_q    <= WIN_TOP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIN_LEFT:   win_left_q   <= $signed(cfg_data);
				REG_WIN_BOTTOM: win_bottom_q <= $signed(cfg_data);
				REG_WIN_RIGHT:  win_right_q  <= $signed(cfg_data);
				REG_WIN_TOP:    win_top_q    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Stage valid bits; a stage advances when it is empty or its successor advances.
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[NS-1];

	// Stage 1: deltas and the boundary terms p and q.
	logic signed [DW-1:0] dx_c, dy_c;
	logic signed [DW-1:0] p_c [4];
	logic signed [DW-1:0] q_c [4];
	logic signed [C-1:0]  x1_s1, y1_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [DW-1:0] p_s1 [4];
	logic signed [DW-1:0] q_s1 [4];

	always_comb begin
		dx_c   = DW'(seg_in.end_x) - DW'(seg_in.start_x);
		dy_c   = DW'(seg_in.end_y) - DW'(seg_in.start_y);
		p_c[0] = -dx_c;
		q_c[0] = DW'(seg_in.start_x) - DW'(win_left_q);
		p_c[1] = dx_c;
		q_c[1] = DW'(win_right_q) - DW'(seg_in.start_x);
		p_c[2] = -dy_c;
		q_c[2] = DW'(seg_in.start_y) - DW'(win_bottom_q);
		p_c[3] = dy_c;
		q_c[3] = DW'(win_top_q) - DW'(seg_in.start_y);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x1_s1 <= seg_in.start_x;
			y1_s1 <= seg_in.start_y;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			for (int l = 0; l < 4; l++) begin
				p_s1[l] <= p_c[l];
				q_s1[l] <= q_c[l];
			end
		end
	end

	// Divider pipeline: index 0 is stage 2, index j holds quotient bits after step j.
	logic [RW-1:0] rem_sd [F+2][4];
	logic [DW-1:0] den_sd [F+2][4];
	logic [TW-1:0] quo_sd [F+2][4];
	lane_ctx_t     ctx_sd [F+2];

	// Stage 2: edge classification, magnitudes and saturation.
	lane_ctx_t     ctx_c;
	logic [DW-1:0] ad_c [4];
	logic [DW-1:0] an_c [4];

	always_comb begin
		ctx_c.x1 = x1_s1;
		ctx_c.y1 = y1_s1;
		ctx_c.dx = dx_s1;
		ctx_c.dy = dy_s1;
		for (int l = 0; l < 4; l++) begin
			ctx_c.rej[l] = ((p_s1[l] == '0) && (q_s1[l] < 0)) ||
				((p_s1[l] > 0) && (q_s1[l] < 0));
			ctx_c.act[l] = (p_s1[l] != '0) &&
				((p_s1[l] < 0) ? (q_s1[l] < 0) : (q_s1[l] >= 0));
			ctx_c.ent[l] = p_s1[l] < 0;
			ad_c[l]      = (p_s1[l] < 0) ? DW'(-p_s1[l]) : DW'(p_s1[l]);
			an_c[l]      = (q_s1[l] < 0) ? DW'(-q_s1[l]) : DW'(q_s1[l]);
			ctx_c.sat[l] = {1'b0, an_c[l]} >= {ad_c[l], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ctx_sd[0] <= ctx_c;
			for (int l = 0; l < 4; l++) begin
				rem_sd[0][l] <= RW'(an_c[l]);
				den_sd[0][l] <= ad_c[l];
				quo_sd[0][l] <= '0;
			end
		end
	end

	// Restoring division for all four edges: each stage compares, subtracts and shifts in a quotient bit.
	for (genvar j = 1; j <= F + 1; j++) begin : g_div
		logic [RW-1:0] nr [4];
		logic [3:0]    ge;

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				ge[l] = rem_sd[j-1][l] >= RW'(den_sd[j-1][l]);
				nr[l] = ge[l] ? (rem_sd[j-1][l] - RW'(den_sd[j-1][l])) : rem_sd[j-1][l];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j+1]) begin
				ctx_sd[j] <= ctx_sd[j-1];
				for (int l = 0; l < 4; l++) begin
					den_sd[j][l] <= den_sd[j-1][l];
					rem_sd[j][l] <= {nr[l][RW-2:0], 1'b0};
					quo_sd[j][l] <= {quo_sd[j-1][l][TW-2:0], ge[l]};
				end
			end
		end
	end

	// Ratios, saturated at the largest unsigned Q1.T_FRAC_BITS value.
	logic [TW-1:0] t_c [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			t_c[l] = ctx_sd[F+1].sat[l] ? '1 : quo_sd[F+1][l];
		end
	end

	// Decision stage A: left and right edges.
	dec_t          dec_init;
	dec_t          dca_c;
	dec_t          dca_s;
	lane_ctx_t     ctxa_s;
	logic [TW-1:0] t23_s [2];

	always_comb begin
		dec_init.ok = 1'b1;
		dec_init.t0 = '0;
		dec_init.t1 = TW'(1) << F;
		dca_c = edge_step(dec_init, ctx_sd[F+1].rej[0], ctx_sd[F+1].act[0],
			ctx_sd[F+1].ent[0], t_c[0]);
		dca_c = edge_step(dca_c, ctx_sd[F+1].rej[1], ctx_sd[F+1].act[1],
			ctx_sd[F+1].ent[1], t_c[1]);
	end

	always_ff @(posedge clk) begin
		if (adv[F+3]) begin
			dca_s    <= dca_c;
			ctxa_s   <= ctx_sd[F+1];
			t23_s[0] <= t_c[2];
			t23_s[1] <= t_c[3];
		end
	end

	// Decision stage B: bottom and top edges.
	dec_t      dcb_c;
	dec_t      dcb_s;
	lane_ctx_t ctxb_s;

	always_comb begin
		dcb_c = edge_step(dca_s, ctxa_s.rej[2], ctxa_s.act[2], ctxa_s.ent[2], t23_s[0]);
		dcb_c = edge_step(dcb_c, ctxa_s.rej[3], ctxa_s.act[3], ctxa_s.ent[3], t23_s[1]);
	end

	always_ff @(posedge clk) begin
		if (adv[F+4]) begin
			dcb_s  <= dcb_c;
			ctxb_s <= ctxa_s;
		end
	end

	// Multiply stage: t times delta for both endpoints.
	logic signed [PW-1:0] prod_s [4];
	logic                 ok_m_s;
	logic signed [C-1:0]  x1_m_s, y1_m_s;

	always_ff @(posedge clk) begin
		if (adv[F+5]) begin
			prod_s[0] <= $signed({1'b0, dcb_s.t0}) * ctxb_s.dx;
			prod_s[1] <= $signed({1'b0, dcb_s.t0}) * ctxb_s.dy;
			prod_s[2] <= $signed({1'b0, dcb_s.t1}) * ctxb_s.dx;
			prod_s[3] <= $signed({1'b0, dcb_s.t1}) * ctxb_s.dy;
			ok_m_s    <= dcb_s.ok;
			x1_m_s    <= ctxb_s.x1;
			y1_m_s    <= ctxb_s.y1;
		end
	end

	// Add stage: base scaled by one plus the product.
	logic signed [SW-1:0] sum_s [4];
	logic                 ok_a_s;

	always_ff @(posedge clk) begin
		if (adv[F+6]) begin
			for (int l = 0; l < 4; l++) begin
				sum_s[l] <= (SW'((l % 2 == 0) ? x1_m_s : y1_m_s) <<< F) + SW'(prod_s[l]);
			end
			ok_a_s <= ok_m_s;
		end
	end

	// Output stage: truncate toward zero and clear rejected results.
	logic signed [SW-1:0] adj_c [4];
	logic signed [SW-1:0] shr_c [4];
	logic [C-1:0]         crd_c [4];
	clip_t                clip_c;
	clip_t                clip_s;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			adj_c[l] = sum_s[l] + ((sum_s[l] < 0) ? SW'((SW'(1) << F) - SW'(1)) : SW'(0));
			shr_c[l] = adj_c[l] >>> F;
			crd_c[l] = ok_a_s ? shr_c[l][C-1:0] : '0;
		end
		clip_c.visible      = ok_a_s;
		clip_c.clip_start_x = $signed(crd_c[0]);
		clip_c.clip_start_y = $signed(crd_c[1]);
		clip_c.clip_end_x   = $signed(crd_c[2]);
		clip_c.clip_end_y   = $signed(crd_c[3]);
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			clip_s <= clip_c;
		end
	end

	assign clip_out = clip_s;

endmodule

>>> sv/lcrw_check.sv
`include "line_clipper_rect_window_assert.svh"

// Port-level checks for the clipper.
module lcrw_check import lcrw_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input seg_t                    seg_in,
	input logic                    out_valid,
	input logic                    out_stall,
	input clip_t                   clip_out,
	input logic                    cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_idx,
	input logic [COORD_BITS-1:0]   cfg_data
);

	// All four result coordinates are zero.
	logic coords_zero;

	assign coords_zero = (clip_out.clip_start_x == 0) && (clip_out.clip_start_y == 0) &&
		(clip_out.clip_end_x == 0) && (clip_out.clip_end_y == 0);

	// A rejected result carries zero endpoints.
	`LCRW_ASSERT_NOW(a_reject_zero, out_valid && !clip_out.visible, coords_zero)

	// Input back-pressure only comes from a stalled result.
	`LCRW_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall)

	// A stalled result is held.
	`LCRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(clip_out))

endmodule

bind line_clipper_rect_window lcrw_check u_lcrw_check (.*);
